@@ hdl/sfpc_pkg.sv @@
// Shared types and constants of the speed feedforward P controller.
`default_nettype none
package sfpc_pkg;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned SMALL_W = 8;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned ERR_W   = SPEED_W + 1;
  localparam int unsigned TERM_W  = 26;
  localparam int unsigned PROD_W  = ERR_W + TERM_W;

  localparam logic [COUNT_W-1:0] LOOP_DELAY = COUNT_W'(100);

  typedef enum logic [2:0] {
    REG_FEED_GAIN      = 3'd0,
    REG_PROP_GAIN      = 3'd1,
    REG_BAND_THRESHOLD = 3'd2,
    REG_TARGET_LEVEL   = 3'd3,
    REG_MAX_TARGET     = 3'd4,
    REG_DRIVE_CEILING  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_PROP,
    MUL_BAND,
    MUL_DRIVE
  } mul_op_t;

  typedef struct packed {
    logic    capture;
    mul_op_t op;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ hdl/sfpc_ctrl.sv @@
// Sequencer that steps one request through the shared multiplier.
`default_nettype none
module sfpc_ctrl
  import sfpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROP,
    ST_BAND,
    ST_DRIVE,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.op      = MUL_NONE;
    cmd.finish  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_PROP;
        end
      end
      ST_PROP: begin
        cmd.op     = MUL_PROP;
        state_next = ST_BAND;
      end
      ST_BAND: begin
        cmd.op     = MUL_BAND;
        state_next = ST_DRIVE;
      end
      ST_DRIVE: begin
        cmd.op     = MUL_DRIVE;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // Hold the finished result until the output register can take it.
        cmd.finish = status.out_free;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule
`default_nettype wire

@@ hdl/sfpc_datapath.sv @@
// Registers, shared multiplier, loop state and output register of the controller.
`default_nettype none
module sfpc_datapath
  import sfpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [SPEED_W-1:0] measured_speed,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SPEED_W-1:0] drive,
  output logic               loop_closed,
  output logic               out_of_band
);

  logic [GAIN_W-1:0]  feed_gain;
  logic [SMALL_W-1:0] prop_gain;
  logic [SMALL_W-1:0] band_threshold;
  logic [SPEED_W-1:0] target_level;
  logic [SPEED_W-1:0] max_target;
  logic [SPEED_W-1:0] drive_ceiling;

  logic               engaged;
  logic [COUNT_W-1:0] delay_count;
  logic               engaged_next;
  logic [COUNT_W-1:0] delay_count_next;
  logic [COUNT_W-1:0] count_inc;

  logic [SPEED_W-1:0]       meas;
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-1:0]         mag;
  logic signed [ERR_W-1:0]  mul_a;
  logic signed [TERM_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [TERM_W-1:0] term;
  logic                     bad;

  logic               prod_pos;
  logic [PROD_W-17:0] prod_shift;
  logic [SPEED_W-1:0] drive_val;

  assign err = $signed({1'b0, target_level}) - $signed({1'b0, meas});
  assign mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      MUL_PROP: begin
        mul_a = $signed({{(ERR_W-SMALL_W){1'b0}}, prop_gain});
        mul_b = $signed({{(TERM_W-ERR_W){err[ERR_W-1]}}, err});
      end
      MUL_BAND: begin
        mul_a = $signed({{(ERR_W-SMALL_W){1'b0}}, band_threshold});
        mul_b = $signed({{(TERM_W-SPEED_W){1'b0}}, target_level});
      end
      MUL_DRIVE: begin
        mul_a = $signed({1'b0, feed_gain});
        mul_b = term;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meas <= measured_speed;
    end
    if (cmd.op != MUL_NONE) begin
      prod <= prod_next;
    end
    if (cmd.op == MUL_BAND) begin
      // prod holds prop_gain * error here.
      term <= engaged ? $signed({{(TERM_W-SPEED_W){1'b0}}, target_level}) + prod[TERM_W-1:0]
                      : $signed({{(TERM_W-SPEED_W){1'b0}}, target_level});
    end
    if (cmd.op == MUL_DRIVE) begin
      // prod holds band_threshold * target_level here.
      bad <= engaged && ({mag, 8'b0} > prod[ERR_W+7:0]);
    end
  end

  // Drive from the signed Q26.16 product: nonpositive gives zero, then saturate.
  assign prod_pos   = !prod[PROD_W-1] && (prod != '0);
  assign prod_shift = prod[PROD_W-1:16];
  always_comb begin
    drive_val = '0;
    if (prod_pos) begin
      if (prod_shift > {{(PROD_W-16-SPEED_W){1'b0}}, drive_ceiling}) begin
        drive_val = drive_ceiling;
      end else begin
        drive_val = prod_shift[SPEED_W-1:0];
      end
    end
  end

  assign count_inc = delay_count + COUNT_W'(1);

  always_comb begin
    engaged_next     = engaged;
    delay_count_next = delay_count;
    if (!engaged) begin
      if (delay_count > LOOP_DELAY) begin
        engaged_next     = 1'b1;
        delay_count_next = '0;
      end else begin
        delay_count_next = count_inc;
      end
    end else if (bad) begin
      if (count_inc > LOOP_DELAY) begin
        engaged_next     = 1'b0;
        delay_count_next = '0;
      end else begin
        delay_count_next = count_inc;
      end
    end else begin
      delay_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_gain      <= GAIN_W'(256);
      prop_gain      <= SMALL_W'(15);
      band_threshold <= SMALL_W'(128);
      target_level   <= '0;
      max_target     <= '1;
      drive_ceiling  <= '1;
      engaged        <= 1'b0;
      delay_count    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FEED_GAIN:      feed_gain      <= cfg_data;
        REG_PROP_GAIN:      prop_gain      <= cfg_data[SMALL_W-1:0];
        REG_BAND_THRESHOLD: band_threshold <= cfg_data[SMALL_W-1:0];
        REG_TARGET_LEVEL: begin
          target_level <= (cfg_data > max_target) ? max_target : cfg_data;
          engaged      <= 1'b0;
          delay_count  <= '0;
        end
        REG_MAX_TARGET:     max_target     <= cfg_data;
        REG_DRIVE_CEILING:  drive_ceiling  <= cfg_data;
        default: ;
      endcase
    end else if (cmd.finish) begin
      engaged     <= engaged_next;
      delay_count <= delay_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      drive       <= drive_val;
      loop_closed <= engaged_next;
      out_of_band <= bad;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule
`default_nettype wire

@@ hdl/speed_feedforward_p_controller.sv @@
// Top level of the speed feedforward P controller.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  measured_speed
//   result    out        out_valid/out_stall  drive, loop_closed, out_of_band
//   config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request is captured in the idle state, then makes three passes through the one shared
// 17x26 multiplier (ST_PROP, ST_BAND, ST_DRIVE) and a finish step (ST_DONE) that loads the
// output register; a new request is accepted only once the previous one has finished.
// in_stall stays high after a request is accepted until its finish step has taken place.
// A stalled result holds the finish step, and the input stays stalled until it moves out.
// rst is synchronous; it resets the state, configuration, loop state and out_valid, not the data registers.
`default_nettype none
module speed_feedforward_p_controller
  import sfpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SPEED_W-1:0] measured_speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SPEED_W-1:0] drive,
  output logic               loop_closed,
  output logic               out_of_band,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  sfpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sfpc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .measured_speed (measured_speed),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive          (drive),
    .loop_closed    (loop_closed),
    .out_of_band    (out_of_band)
  );

  // An accepted request keeps the input stalled while it is processed.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted request");

  // A new result only appears at the end of processing.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
